// ===== design/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner package
// Shared types, codes and widths of the conditioner and its divider.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned LUX_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned ADJ_W   = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NUM_W   = 23;
  localparam int unsigned DEN_W   = 17;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned WIN_SIZE = 3;
  localparam int unsigned FILL_W  = 2;

  localparam int unsigned LUX_MUL   = 5;
  localparam int unsigned LUX_ADD   = 3;
  localparam int unsigned LUX_DIV   = 6;
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned MODE_HIGH_LUX = 100;

  // (raw*5+3)/6 as (n * ceil(2^22/6)) >> 22, exact for every n below 2^19
  localparam int unsigned LUX_NUM_W  = 19;
  localparam int unsigned LUX_RECIP  = 699051;
  localparam int unsigned LUX_SHIFT  = 22;
  localparam int unsigned LUX_PROD_W = 39;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_HIGH  = 2'd0,
    MODE_HIGH2 = 2'd1,
    MODE_LOW   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LINK_ERR  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_FILTER_EN  = 3'd0,
    REG_AUTO_GAIN  = 3'd1,
    REG_MIN_LUX    = 3'd2,
    REG_OVF_THRESH = 3'd3,
    REG_DIM_THRESH = 3'd4,
    REG_BRT_THRESH = 3'd5,
    REG_ADJ_INTVL  = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LUX_MUL,
    S_CHECK,
    S_GAIN,
    S_PCT_START,
    S_PCT_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== design/lrc_in_if.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner input channel
// Valid/ready channel carrying one command or sensor reading per item.
// ----------------------------------------------------------------------------
interface lrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        link_ok;
  logic [15:0] raw_reading;
  logic [1:0]  new_mode;

  modport source (output valid, output opcode, output link_ok, output raw_reading,
                  output new_mode, input ready);
  modport sink (input valid, input opcode, input link_ok, input raw_reading,
                input new_mode, output ready);
endinterface

// ===== design/lrc_out_if.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner output channel
// Valid/ready channel carrying one result item per accepted input item.
// ----------------------------------------------------------------------------
interface lrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] lux;
  logic [1:0]  mode;
  logic        saturated;
  logic [15:0] good_cnt;
  logic [15:0] fail_cnt;
  logic [15:0] sat_cnt;
  logic [6:0]  success_percent;

  modport source (output valid, output status, output lux, output mode, output saturated,
                  output good_cnt, output fail_cnt, output sat_cnt,
                  output success_percent, input ready);
  modport sink (input valid, input status, input lux, input mode, input saturated,
                input good_cnt, input fail_cnt, input sat_cnt,
                input success_percent, output ready);
endinterface

// ===== design/lrc_div.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner divider
// Radix-2 restoring divider, one quotient bit per cycle, used for the success
// percentage.
// ----------------------------------------------------------------------------
module lrc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrc_pkg::div_req_t req_i,
  output lrc_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [lrc_pkg::STEP_W-1:0]   step_q, step_d;
  logic [lrc_pkg::NUM_W-1:0]    num_q, num_d;
  logic [lrc_pkg::DEN_W-1:0]    den_q, den_d;
  logic [lrc_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [lrc_pkg::DEN_W:0]      trial;
  logic                         fits;

  assign trial = {rem_q, num_q[lrc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = lrc_pkg::STEP_W'(lrc_pkg::NUM_W);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d  = {num_q[lrc_pkg::NUM_W-2:0], fits};
      rem_d  = fits ? lrc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[lrc_pkg::DEN_W-1:0];
      step_d = step_q - lrc_pkg::STEP_W'(1);
      if (step_q == lrc_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== design/light_reading_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner unit
// Converts raw light counts to lux, flags saturation, optionally median
// filters, switches resolution mode and keeps link statistics.
// ----------------------------------------------------------------------------
// One item at a time. A good sample passes S_LUX_MUL, S_CHECK, S_GAIN, S_PCT_START,
// S_PCT_DIV and S_OUT; an underflow or overflow skips S_GAIN and every other item
// goes straight to S_PCT_START. The input is ready again once the result is
// registered. The longest step is the 23-step radix-2 divider that
// forms the success percentage; the lux value (raw*5+3)/6 comes from a
// reciprocal multiplication whose product is registered in S_LUX_MUL. A
// finished result sits in an output register, so a new item is taken while
// the previous result still waits downstream; if that result is still held
// when the next one is finished, the unit stalls until it leaves.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must do so only while the unit is idle, the unit does not enforce it.
module light_reading_conditioner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  lrc_in_if.sink      in_i,
  lrc_out_if.source   out_o
);

  lrc_pkg::state_e              state_q, state_d;
  lrc_pkg::div_req_t            div_req;
  lrc_pkg::div_rsp_t            div_rsp;

  logic                         filter_en_q, auto_gain_q;
  logic [lrc_pkg::LUX_W-1:0]    min_lux_q, ovf_thr_q, dim_thr_q, brt_thr_q;
  logic [lrc_pkg::ADJ_W-1:0]    adj_intvl_q;

  lrc_pkg::mode_e               mode_q;
  logic [lrc_pkg::ADJ_W-1:0]    adj_cnt_q;
  logic [lrc_pkg::CNT_W-1:0]    good_q, fail_q, sat_cnt_q;
  logic [lrc_pkg::LUX_W-1:0]    win_q [lrc_pkg::WIN_SIZE];
  logic [lrc_pkg::FILL_W-1:0]   fill_q;
  logic [lrc_pkg::LUX_W-1:0]    last_lux_q;
  logic                         last_sat_q;
  lrc_pkg::status_e             status_q;
  logic [lrc_pkg::LUX_W-1:0]    lux_q, filt_q;
  logic [lrc_pkg::PCT_W-1:0]    pct_q;
  logic [lrc_pkg::LUX_NUM_W-1:0] lux_num_q;

  logic                         out_valid_q;
  lrc_pkg::status_e             out_status_q;
  logic [lrc_pkg::LUX_W-1:0]    out_lux_q;
  lrc_pkg::mode_e               out_mode_q;
  logic                         out_sat_q;
  logic [lrc_pkg::CNT_W-1:0]    out_good_q, out_fail_q, out_satc_q;
  logic [lrc_pkg::PCT_W-1:0]    out_pct_q;

  logic                         in_acc;
  logic                         out_free;
  logic [lrc_pkg::DEN_W-1:0]    total;
  logic [lrc_pkg::FILL_W-1:0]   fill_nx;
  logic [lrc_pkg::LUX_W-1:0]    med_lo, med_hi, med_mid, med;
  logic [lrc_pkg::ADJ_W-1:0]    adj_inc;
  logic [lrc_pkg::LUX_PROD_W-1:0] lux_prod;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign total    = lrc_pkg::DEN_W'(good_q) + lrc_pkg::DEN_W'(fail_q);
  assign fill_nx  = (fill_q == lrc_pkg::FILL_W'(lrc_pkg::WIN_SIZE)) ? fill_q
                                                                    : fill_q + lrc_pkg::FILL_W'(1);
  assign med_lo   = (lux_q < win_q[0]) ? lux_q : win_q[0];
  assign med_hi   = (lux_q < win_q[0]) ? win_q[0] : lux_q;
  assign med_mid  = (med_hi < win_q[1]) ? med_hi : win_q[1];
  assign med      = (med_lo > med_mid) ? med_lo : med_mid;
  assign adj_inc  = adj_cnt_q + lrc_pkg::ADJ_W'(1);
  assign lux_prod = lrc_pkg::LUX_PROD_W'(lux_num_q) * lrc_pkg::LUX_PROD_W'(lrc_pkg::LUX_RECIP);

  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    div_req     = '0;
    unique case (state_q)
      lrc_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          if (in_i.opcode == lrc_pkg::OP_SAMPLE && in_i.link_ok) begin
            state_d = lrc_pkg::S_LUX_MUL;
          end else begin
            state_d = lrc_pkg::S_PCT_START;
          end
        end
      end
      lrc_pkg::S_LUX_MUL: begin
        state_d = lrc_pkg::S_CHECK;
      end
      lrc_pkg::S_CHECK: begin
        if (lux_q < min_lux_q || lux_q > ovf_thr_q) state_d = lrc_pkg::S_PCT_START;
        else state_d = lrc_pkg::S_GAIN;
      end
      lrc_pkg::S_GAIN: begin
        state_d = lrc_pkg::S_PCT_START;
      end
      lrc_pkg::S_PCT_START: begin
        div_req.start = 1'b1;
        div_req.num   = lrc_pkg::NUM_W'(good_q) * lrc_pkg::NUM_W'(lrc_pkg::PCT_SCALE);
        div_req.den   = total;
        state_d       = lrc_pkg::S_PCT_DIV;
      end
      lrc_pkg::S_PCT_DIV: begin
        if (div_rsp.done) state_d = lrc_pkg::S_OUT;
      end
      lrc_pkg::S_OUT: begin
        if (out_free) state_d = lrc_pkg::S_IDLE;
      end
      default: state_d = lrc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      auto_gain_q <= 1'b0;
      min_lux_q   <= lrc_pkg::LUX_W'(5);
      ovf_thr_q   <= lrc_pkg::LUX_W'(50000);
      dim_thr_q   <= lrc_pkg::LUX_W'(10);
      brt_thr_q   <= lrc_pkg::LUX_W'(10000);
      adj_intvl_q <= lrc_pkg::ADJ_W'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrc_pkg::REG_FILTER_EN:  filter_en_q <= cfg_wdata_i[0];
        lrc_pkg::REG_AUTO_GAIN:  auto_gain_q <= cfg_wdata_i[0];
        lrc_pkg::REG_MIN_LUX:    min_lux_q   <= cfg_wdata_i;
        lrc_pkg::REG_OVF_THRESH: ovf_thr_q   <= cfg_wdata_i;
        lrc_pkg::REG_DIM_THRESH: dim_thr_q   <= cfg_wdata_i;
        lrc_pkg::REG_BRT_THRESH: brt_thr_q   <= cfg_wdata_i;
        lrc_pkg::REG_ADJ_INTVL:  adj_intvl_q <= cfg_wdata_i[lrc_pkg::ADJ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= lrc_pkg::MODE_HIGH;
      adj_cnt_q  <= '0;
      good_q     <= '0;
      fail_q     <= '0;
      sat_cnt_q  <= '0;
      for (int i = 0; i < lrc_pkg::WIN_SIZE; i++) win_q[i] <= '0;
      fill_q     <= '0;
      last_lux_q <= '0;
      last_sat_q <= 1'b0;
      status_q   <= lrc_pkg::ST_OK;
    end else begin
      unique case (state_q)
        lrc_pkg::S_IDLE: begin
          if (in_acc) begin
            unique case (in_i.opcode)
              lrc_pkg::OP_SAMPLE: begin
                if (!in_i.link_ok) begin
                  fail_q   <= fail_q + lrc_pkg::CNT_W'(1);
                  status_q <= lrc_pkg::ST_LINK_ERR;
                end else begin
                  status_q <= lrc_pkg::ST_OK;
                end
              end
              lrc_pkg::OP_SET_MODE: begin
                if (!in_i.link_ok) begin
                  status_q <= lrc_pkg::ST_LINK_ERR;
                end else begin
                  status_q <= lrc_pkg::ST_OK;
                  if (in_i.new_mode == lrc_pkg::MODE_HIGH ||
                      in_i.new_mode == lrc_pkg::MODE_HIGH2 ||
                      in_i.new_mode == lrc_pkg::MODE_LOW) begin
                    mode_q <= lrc_pkg::mode_e'(in_i.new_mode);
                  end
                end
              end
              lrc_pkg::OP_CLEAR: begin
                status_q  <= lrc_pkg::ST_OK;
                good_q    <= '0;
                fail_q    <= '0;
                sat_cnt_q <= '0;
                adj_cnt_q <= '0;
                if (filter_en_q) begin
                  for (int i = 0; i < lrc_pkg::WIN_SIZE; i++) win_q[i] <= '0;
                  fill_q <= '0;
                end
              end
              default: status_q <= lrc_pkg::ST_OK;
            endcase
          end
        end
        lrc_pkg::S_CHECK: begin
          if (lux_q < min_lux_q) begin
            last_lux_q <= '0;
            last_sat_q <= 1'b1;
            sat_cnt_q  <= sat_cnt_q + lrc_pkg::CNT_W'(1);
            status_q   <= lrc_pkg::ST_UNDERFLOW;
          end else if (lux_q > ovf_thr_q) begin
            last_lux_q <= lux_q;
            last_sat_q <= 1'b1;
            sat_cnt_q  <= sat_cnt_q + lrc_pkg::CNT_W'(1);
            status_q   <= lrc_pkg::ST_OVERFLOW;
          end else begin
            last_sat_q <= 1'b0;
            if (filter_en_q) begin
              for (int i = lrc_pkg::WIN_SIZE - 1; i > 0; i--) win_q[i] <= win_q[i-1];
              win_q[0] <= lux_q;
              fill_q   <= fill_nx;
            end
          end
        end
        lrc_pkg::S_GAIN: begin
          if (auto_gain_q) begin
            if (adj_inc < adj_intvl_q) begin
              adj_cnt_q <= adj_inc;
            end else begin
              adj_cnt_q <= '0;
              priority if (filt_q < dim_thr_q && mode_q != lrc_pkg::MODE_HIGH2) begin
                mode_q <= lrc_pkg::MODE_HIGH2;
              end else if (filt_q > brt_thr_q && mode_q != lrc_pkg::MODE_LOW) begin
                mode_q <= lrc_pkg::MODE_LOW;
              end else if (filt_q > lrc_pkg::LUX_W'(lrc_pkg::MODE_HIGH_LUX) &&
                           filt_q < brt_thr_q && mode_q != lrc_pkg::MODE_HIGH) begin
                mode_q <= lrc_pkg::MODE_HIGH;
              end else begin
                mode_q <= mode_q;
              end
            end
          end
          last_lux_q <= filt_q;
          good_q     <= good_q + lrc_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lrc_pkg::S_IDLE && in_acc) begin
      lux_num_q <= lrc_pkg::LUX_NUM_W'(in_i.raw_reading) * lrc_pkg::LUX_NUM_W'(lrc_pkg::LUX_MUL)
                 + lrc_pkg::LUX_NUM_W'(lrc_pkg::LUX_ADD);
    end
    if (state_q == lrc_pkg::S_LUX_MUL) begin
      lux_q <= lux_prod[lrc_pkg::LUX_SHIFT +: lrc_pkg::LUX_W];
    end
    if (state_q == lrc_pkg::S_CHECK) begin
      filt_q <= (filter_en_q && fill_nx == lrc_pkg::FILL_W'(lrc_pkg::WIN_SIZE)) ? med : lux_q;
    end
    if (state_q == lrc_pkg::S_PCT_DIV && div_rsp.done) begin
      pct_q <= (total == '0) ? '0 : div_rsp.quot[lrc_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lrc_pkg::S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lrc_pkg::S_OUT && out_free) begin
      out_status_q <= status_q;
      out_lux_q    <= last_lux_q;
      out_mode_q   <= mode_q;
      out_sat_q    <= last_sat_q;
      out_good_q   <= good_q;
      out_fail_q   <= fail_q;
      out_satc_q   <= sat_cnt_q;
      out_pct_q    <= pct_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.lux             = out_lux_q;
  assign out_o.mode            = out_mode_q;
  assign out_o.saturated       = out_sat_q;
  assign out_o.good_cnt        = out_good_q;
  assign out_o.fail_cnt        = out_fail_q;
  assign out_o.sat_cnt         = out_satc_q;
  assign out_o.success_percent = out_pct_q;

  lrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

// ===== bench/lrc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Light reading result checker
// Watches the input and result channels and the register write port of the
// light reading conditioner. Predicts each result from the accepted items and
// compares it, field by field, with what the unit returns, in order.
// ----------------------------------------------------------------------------
module lrc_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  lrc_in_if           in_mon_i,
  lrc_out_if          out_mon_i,
  output int unsigned mismatches_o,
  output int unsigned waiting_o,
  output int unsigned compared_o
);

  typedef struct packed {
    lrc_pkg::status_e          status;
    logic [lrc_pkg::LUX_W-1:0] lux;
    lrc_pkg::mode_e            mode;
    logic                      saturated;
    logic [lrc_pkg::CNT_W-1:0] good;
    logic [lrc_pkg::CNT_W-1:0] fails;
    logic [lrc_pkg::CNT_W-1:0] sats;
    logic [lrc_pkg::PCT_W-1:0] pct;
  } reading_result_t;

  reading_result_t expected_results[$];

  bit                        cfg_filter;
  bit                        cfg_auto;
  logic [lrc_pkg::LUX_W-1:0] cfg_min;
  logic [lrc_pkg::LUX_W-1:0] cfg_ovf;
  logic [lrc_pkg::LUX_W-1:0] cfg_dim;
  logic [lrc_pkg::LUX_W-1:0] cfg_bright;
  logic [lrc_pkg::ADJ_W-1:0] cfg_interval;

  lrc_pkg::mode_e            mode_q;
  logic [lrc_pkg::ADJ_W-1:0] gain_tick;
  logic [lrc_pkg::CNT_W-1:0] ok_total;
  logic [lrc_pkg::CNT_W-1:0] link_errs;
  logic [lrc_pkg::CNT_W-1:0] sat_total;
  logic [lrc_pkg::LUX_W-1:0] window [lrc_pkg::WIN_SIZE];
  int unsigned               window_count;
  logic [lrc_pkg::LUX_W-1:0] held_lux;
  logic                      held_sat;

  int unsigned mismatches = 0;
  int unsigned compared = 0;

  assign mismatches_o = mismatches;
  assign compared_o   = compared;
  assign waiting_o    = expected_results.size();

  task automatic reset_prediction();
    cfg_filter   = 1'b0;
    cfg_auto     = 1'b0;
    cfg_min      = 16'd5;
    cfg_ovf      = 16'd50000;
    cfg_dim      = 16'd10;
    cfg_bright   = 16'd10000;
    cfg_interval = 8'd20;
    mode_q       = lrc_pkg::MODE_HIGH;
    gain_tick    = '0;
    ok_total     = '0;
    link_errs    = '0;
    sat_total    = '0;
    for (int i = 0; i < lrc_pkg::WIN_SIZE; i++) window[i] = '0;
    window_count = 0;
    held_lux     = '0;
    held_sat     = 1'b0;
    expected_results.delete();
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [15:0] val);
    case (lrc_pkg::reg_idx_e'(idx))
      lrc_pkg::REG_FILTER_EN:  cfg_filter   = val[0];
      lrc_pkg::REG_AUTO_GAIN:  cfg_auto     = val[0];
      lrc_pkg::REG_MIN_LUX:    cfg_min      = val;
      lrc_pkg::REG_OVF_THRESH: cfg_ovf      = val;
      lrc_pkg::REG_DIM_THRESH: cfg_dim      = val;
      lrc_pkg::REG_BRT_THRESH: cfg_bright   = val;
      lrc_pkg::REG_ADJ_INTVL:  cfg_interval = val[lrc_pkg::ADJ_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [lrc_pkg::LUX_W-1:0] middle_of(logic [lrc_pkg::LUX_W-1:0] a,
                                                          logic [lrc_pkg::LUX_W-1:0] b,
                                                          logic [lrc_pkg::LUX_W-1:0] c);
    logic [lrc_pkg::LUX_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  task automatic push_window(input logic [lrc_pkg::LUX_W-1:0] v,
                             output logic [lrc_pkg::LUX_W-1:0] m);
    for (int i = lrc_pkg::WIN_SIZE - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = v;
    if (window_count < lrc_pkg::WIN_SIZE) window_count++;
    m = (window_count < lrc_pkg::WIN_SIZE) ? v : middle_of(window[0], window[1], window[2]);
  endtask

  task automatic decide_mode(input logic [lrc_pkg::LUX_W-1:0] f);
    gain_tick++;
    if (gain_tick < cfg_interval) return;
    gain_tick = '0;
    if (f < cfg_dim && mode_q != lrc_pkg::MODE_HIGH2) begin
      mode_q = lrc_pkg::MODE_HIGH2;
    end else if (f > cfg_bright && mode_q != lrc_pkg::MODE_LOW) begin
      mode_q = lrc_pkg::MODE_LOW;
    end else if (f > lrc_pkg::MODE_HIGH_LUX && f < cfg_bright &&
                 mode_q != lrc_pkg::MODE_HIGH) begin
      mode_q = lrc_pkg::MODE_HIGH;
    end
  endtask

  task automatic predict_reading(input logic [1:0] op, input logic link,
                                 input logic [15:0] raw, input logic [1:0] nm,
                                 output reading_result_t r);
    lrc_pkg::status_e          st;
    int unsigned               conv;
    int unsigned               total;
    logic [lrc_pkg::LUX_W-1:0] filt;
    st = lrc_pkg::ST_OK;
    case (op)
      lrc_pkg::OP_SAMPLE: begin
        if (!link) begin
          link_errs++;
          st = lrc_pkg::ST_LINK_ERR;
        end else begin
          conv = (32'(raw) * lrc_pkg::LUX_MUL + lrc_pkg::LUX_ADD) / lrc_pkg::LUX_DIV;
          held_sat = 1'b0;
          if (conv < cfg_min) begin
            held_lux = '0;
            held_sat = 1'b1;
            sat_total++;
            st = lrc_pkg::ST_UNDERFLOW;
          end else if (conv > cfg_ovf) begin
            held_lux = lrc_pkg::LUX_W'(conv);
            held_sat = 1'b1;
            sat_total++;
            st = lrc_pkg::ST_OVERFLOW;
          end else begin
            if (cfg_filter) push_window(lrc_pkg::LUX_W'(conv), filt);
            else filt = lrc_pkg::LUX_W'(conv);
            if (cfg_auto) decide_mode(filt);
            held_lux = filt;
            ok_total++;
          end
        end
      end
      lrc_pkg::OP_SET_MODE: begin
        if (!link) st = lrc_pkg::ST_LINK_ERR;
        else if (nm <= lrc_pkg::MODE_LOW) mode_q = lrc_pkg::mode_e'(nm);
      end
      lrc_pkg::OP_CLEAR: begin
        ok_total  = '0;
        link_errs = '0;
        sat_total = '0;
        gain_tick = '0;
        if (cfg_filter) begin
          for (int i = 0; i < lrc_pkg::WIN_SIZE; i++) window[i] = '0;
          window_count = 0;
        end
      end
      default: ;
    endcase
    total       = 32'(ok_total) + 32'(link_errs);
    r.status    = st;
    r.lux       = held_lux;
    r.mode      = mode_q;
    r.saturated = held_sat;
    r.good      = ok_total;
    r.fails     = link_errs;
    r.sats      = sat_total;
    r.pct       = (total != 0) ?
                  lrc_pkg::PCT_W'((32'(ok_total) * lrc_pkg::PCT_SCALE) / total) : '0;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", compared, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    reading_result_t want;
    if (!rst_ni) begin
      reset_prediction();
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_wdata_i);
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no item waiting: status %0d lux %0d",
                     out_mon_i.status, out_mon_i.lux);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_mon_i.status));
          compare_field("lux", 32'(want.lux), 32'(out_mon_i.lux));
          compare_field("mode", 32'(want.mode), 32'(out_mon_i.mode));
          compare_field("saturated", 32'(want.saturated), 32'(out_mon_i.saturated));
          compare_field("good_cnt", 32'(want.good), 32'(out_mon_i.good_cnt));
          compare_field("fail_cnt", 32'(want.fails), 32'(out_mon_i.fail_cnt));
          compare_field("sat_cnt", 32'(want.sats), 32'(out_mon_i.sat_cnt));
          compare_field("success_percent", 32'(want.pct), 32'(out_mon_i.success_percent));
        end
        compared++;
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_reading(in_mon_i.opcode, in_mon_i.link_ok, in_mon_i.raw_reading,
                        in_mon_i.new_mode, want);
        expected_results.push_back(want);
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Light reading conditioner testbench
// Drives readings, mode commands and statistics clears into the unit under
// several register settings, with random gaps and a long result stall, and
// leaves prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0]  OP_RESERVED   = 2'd3;
  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned settings    = 0;
  int unsigned cycle_count = 0;
  logic [15:0] reg_value [7];

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned compared;

  lrc_in_if  in_if ();
  lrc_out_if out_if ();

  light_reading_conditioner_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  lrc_result_checker i_results (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .compared_o   (compared)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid       = 1'b0;
    in_if.opcode      = lrc_pkg::OP_SAMPLE;
    in_if.link_ok     = 1'b0;
    in_if.raw_reading = '0;
    in_if.new_mode    = lrc_pkg::MODE_HIGH;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_if.ready <= !(idle_on && $urandom_range(99) < 13);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic link, input logic [15:0] raw,
                           input logic [1:0] nm);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.link_ok     <= link;
    in_if.raw_reading <= raw;
    in_if.new_mode    <= nm;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input lrc_pkg::reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    reg_value[idx] = val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_registers(input bit filt, input bit gain, input logic [15:0] min_l,
                               input logic [15:0] ovf, input logic [15:0] dim,
                               input logic [15:0] bright, input logic [7:0] intvl);
    wait_results();
    write_reg(lrc_pkg::REG_FILTER_EN, 16'(filt));
    write_reg(lrc_pkg::REG_AUTO_GAIN, 16'(gain));
    write_reg(lrc_pkg::REG_MIN_LUX, min_l);
    write_reg(lrc_pkg::REG_OVF_THRESH, ovf);
    write_reg(lrc_pkg::REG_DIM_THRESH, dim);
    write_reg(lrc_pkg::REG_BRT_THRESH, bright);
    write_reg(lrc_pkg::REG_ADJ_INTVL, 16'(intvl));
    settings++;
  endtask

  function automatic logic [15:0] pick_raw();
    int target;
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(40));
      default: begin
        case ($urandom_range(4))
          0: target = int'(reg_value[lrc_pkg::REG_MIN_LUX]);
          1: target = int'(reg_value[lrc_pkg::REG_OVF_THRESH]);
          2: target = int'(reg_value[lrc_pkg::REG_DIM_THRESH]);
          3: target = int'(reg_value[lrc_pkg::REG_BRT_THRESH]);
          default: target = int'(lrc_pkg::MODE_HIGH_LUX);
        endcase
        target = target * 6 / 5 + int'($urandom_range(4)) - 2;
        if (target < 0) target = 0;
        if (target > 65535) target = 65535;
        return 16'(target);
      end
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned pick;
    logic [1:0]  op;
    logic        link;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        op   = lrc_pkg::OP_SAMPLE;
        link = ($urandom_range(99) >= 8);
      end else begin
        if (pick < 90) op = lrc_pkg::OP_SET_MODE;
        else if (pick < 95) op = lrc_pkg::OP_CLEAR;
        else op = OP_RESERVED;
        link = ($urandom_range(99) >= 10);
      end
      send_item(op, link, pick_raw(), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    reg_value[lrc_pkg::REG_FILTER_EN]  = 16'd0;
    reg_value[lrc_pkg::REG_AUTO_GAIN]  = 16'd0;
    reg_value[lrc_pkg::REG_MIN_LUX]    = 16'd5;
    reg_value[lrc_pkg::REG_OVF_THRESH] = 16'd50000;
    reg_value[lrc_pkg::REG_DIM_THRESH] = 16'd10;
    reg_value[lrc_pkg::REG_BRT_THRESH] = 16'd10000;
    reg_value[lrc_pkg::REG_ADJ_INTVL]  = 16'd20;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(lrc_pkg::OP_SAMPLE, 1'b0, 16'hFFFF, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd0, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd5, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd6, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd60000, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd60001, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'hFFFF, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SET_MODE, 1'b1, 16'd0, lrc_pkg::MODE_LOW);
    send_item(lrc_pkg::OP_SET_MODE, 1'b1, 16'd0, lrc_pkg::MODE_HIGH2);
    send_item(lrc_pkg::OP_SET_MODE, 1'b0, 16'd0, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SET_MODE, 1'b1, 16'd0, MODE_RESERVED);
    send_item(lrc_pkg::OP_SET_MODE, 1'b1, 16'd0, lrc_pkg::MODE_HIGH);
    send_item(OP_RESERVED, 1'b1, 16'h5555, lrc_pkg::MODE_LOW);
    send_item(lrc_pkg::OP_CLEAR, 1'b1, 16'd0, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'hAAAA, lrc_pkg::MODE_HIGH);

    set_registers(1'b1, 1'b1, 16'd5, 16'd50000, 16'd10, 16'd10000, 8'd1);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd120, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd12, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd6, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd7, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd7, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd24000, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd24000, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b0, 16'd24000, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd1200, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd1200, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_CLEAR, 1'b1, 16'd0, lrc_pkg::MODE_HIGH);
    send_item(lrc_pkg::OP_SAMPLE, 1'b1, 16'd3000, lrc_pkg::MODE_HIGH);

    set_registers(1'b0, 1'b0, 16'd5, 16'd50000, 16'd10, 16'd10000, 8'd20);
    run_random(30);
    hold_req = 1'b1;
    run_random(30);
    wait_results();
    run_random(40);

    idle_on = 1'b0;
    set_registers(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'd10, 16'd10000, 8'd1);
    run_random(120);
    idle_on = 1'b1;

    set_registers(1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd2);
    run_random(40);

    set_registers(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'd3);
    run_random(80);

    set_registers(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'd50, 16'd20000, 8'd255);
    run_random(120);

    set_registers(1'($urandom_range(1)), 1'($urandom_range(1)),
                  16'($urandom_range(200)), 16'($urandom_range(65535, 20000)),
                  16'($urandom_range(3000)), 16'($urandom_range(40000, 3000)),
                  8'($urandom_range(8, 1)));
    run_random(60);
    wait_results();
    run_random(60);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over %0d register settings, %0d results compared,",
             items_sent, settings + 1, compared);
    $display("including a %0d-cycle result stall and runs with no idling.", HOLD_CYCLES);
    if (mismatches == 0 && waiting == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
